/* rtl/y2r_pkg.sv */
// Shared types, constants and helper functions for the 4:2:0 YCbCr to RGB converter.
package y2r_pkg;

	// Sample and register widths.
	localparam int SAMPLE_W    = 8;
	localparam int STD_W       = 2;
	localparam int ROW_WIDTH_W = 13;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 13;
	localparam int COEF_W      = 10;
	localparam int FRAC_BITS   = 8;

	// Defaults and reset values.
	localparam int DEFAULT_MAX_WIDTH = 4096;
	localparam logic [ROW_WIDTH_W-1:0] RESET_ROW_WIDTH = 13'd1920;

	// Chroma samples carry an offset of half the sample range.
	localparam logic [SAMPLE_W-1:0] CHROMA_OFFSET = 8'd128;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = 8'd255;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_STANDARD = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH      = 1'd1;

	// Colour standard codes.
	localparam logic [STD_W-1:0] STD_BT601  = 2'd0;
	localparam logic [STD_W-1:0] STD_BT709  = 2'd1;
	localparam logic [STD_W-1:0] STD_BT2020 = 2'd2;

	// Input pixel transaction.
	typedef struct packed {
		logic [SAMPLE_W-1:0] luma;
		logic [SAMPLE_W-1:0] chroma_blue;
		logic [SAMPLE_W-1:0] chroma_red;
		logic                frame_start;
	} pixel_in_t;

	// Output pixel transaction.
	typedef struct packed {
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
	} pixel_out_t;

	// One set of signed Q1.8 conversion coefficients; the two green ones are negative.
	typedef struct packed {
		logic signed [COEF_W-1:0] krv;
		logic signed [COEF_W-1:0] kgu;
		logic signed [COEF_W-1:0] kgv;
		logic signed [COEF_W-1:0] kbu;
	} coef_set_t;

	// Coefficient lookup; the unused code falls back to BT.2020.
	function automatic coef_set_t coef_lookup(input logic [STD_W-1:0] std_sel);
		coef_set_t c;
		unique case (std_sel)
			STD_BT601: begin
				c.krv = 10'sd360;
				c.kgu = -10'sd88;
				c.kgv = -10'sd184;
				c.kbu = 10'sd455;
			end
			STD_BT709: begin
				c.krv = 10'sd404;
				c.kgu = -10'sd48;
				c.kgv = -10'sd120;
				c.kbu = 10'sd475;
			end
			default: begin
				c.krv = 10'sd377;
				c.kgu = -10'sd42;
				c.kgv = -10'sd133;
				c.kbu = 10'sd482;
			end
		endcase
		return c;
	endfunction

	// Clamp a signed channel value into the unsigned sample range.
	function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic signed [12:0] x);
		logic [SAMPLE_W-1:0] res;
		if (x < 13'sd0) begin
			res = '0;
		end else if (x > 13'sd255) begin
			res = SAMPLE_MAX;
		end else begin
			res = x[SAMPLE_W-1:0];
		end
		return res;
	endfunction

endpackage

/* rtl/y2r_stream_if.sv */
// Valid/ready stream interface carrying one payload per transaction.
interface y2r_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/yuv420_to_rgb_converter.sv */
// An accepted input is registered in stage 1, stage 2 and the output register in turn.
// Throughput: one pixel per cycle unless the output stalls; the chroma line store has one
// synchronous port and is written on even rows and read on odd rows, so it never sees two
// accesses in one cycle. The whole pipeline holds while the output register is full and
// not taken. Reset (arst_n, asynchronous) clears the raster position, held chroma, valid
// flags and configuration registers; the line store is not cleared and needs no clearing pass.
module yuv420_to_rgb_converter #(
	parameter int MAX_WIDTH = y2r_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_enable,
	input  logic [y2r_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [y2r_pkg::CFG_DATA_W-1:0]  cfg_data,
	y2r_stream_if.sink                      pixel_in,
	y2r_stream_if.source                    pixel_out
);
	import y2r_pkg::*;

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int CNT_W      = COL_W + 1;
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int SLOT_W     = $clog2(LINE_DEPTH);

	// Configuration registers.
	logic [STD_W-1:0]       color_standard_q;
	logic [ROW_WIDTH_W-1:0] row_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_standard_q <= STD_BT601;
			row_width_q      <= RESET_ROW_WIDTH;
		end else if (cfg_write_enable) begin
			if (cfg_index == REG_COLOR_STANDARD) begin
				color_standard_q <= cfg_data[STD_W-1:0];
			end
			if (cfg_index == REG_ROW_WIDTH) begin
				row_width_q <= cfg_data[ROW_WIDTH_W-1:0];
			end
		end
	end

	// Pipeline control: every stage moves when the output register can take a result.
	logic advance;
	logic accept;
	logic valid_s1, valid_s2, out_valid_q;

	assign advance        = !out_valid_q || pixel_out.ready;
	assign pixel_in.ready = advance;
	assign accept         = pixel_in.valid && advance;

	// Raster position, with a frame start forcing row 0, column 0.
	logic [COL_W-1:0]   col_q;
	logic               odd_q;
	logic [COL_W-1:0]   col_eff;
	logic               odd_eff;
	logic [CNT_W-1:0]   width_eff;
	logic [CNT_W-1:0]   col_inc;
	logic               width_bad;
	logic [COL_W-2:0]   slot;
	logic               slot_ok;
	logic               touch;
	logic               mem_we;
	logic               mem_re;

	always_comb begin
		col_eff   = pixel_in.payload.frame_start ? '0 : col_q;
		odd_eff   = pixel_in.payload.frame_start ? 1'b0 : odd_q;
		width_bad = (row_width_q == '0) || (32'(row_width_q) > 32'(MAX_WIDTH));
		width_eff = width_bad ? CNT_W'(MAX_WIDTH) : CNT_W'(row_width_q);
		col_inc   = {1'b0, col_eff} + CNT_W'(1);
		slot      = col_eff[COL_W-1:1];
		slot_ok   = 32'(slot) < 32'(LINE_DEPTH);
		touch     = accept && !col_eff[0] && slot_ok;
		mem_we    = touch && !odd_eff;
		mem_re    = touch && odd_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			odd_q <= 1'b0;
		end else if (accept) begin
			if (col_inc >= width_eff) begin
				col_q <= '0;
				odd_q <= !odd_eff;
			end else begin
				col_q <= col_inc[COL_W-1:0];
				odd_q <= odd_eff;
			end
		end
	end

	// Chroma line store: even rows write the pair, odd rows read it back a row later.
	logic [2*SAMPLE_W-1:0] line_mem [LINE_DEPTH];
	logic [2*SAMPLE_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[slot[SLOT_W-1:0]] <= {pixel_in.payload.chroma_red,
				pixel_in.payload.chroma_blue};
		end
		if (mem_re) begin
			rd_q <= line_mem[slot[SLOT_W-1:0]];
		end
	end

	// Stage 1 registers: luma, incoming chroma and how this pixel obtains its chroma.
	logic [SAMPLE_W-1:0] y_s1, cb_s1, cr_s1;
	logic                load_s1;
	logic                odd_s1;

	always_ff @(posedge clk) begin
		if (advance) begin
			y_s1    <= pixel_in.payload.luma;
			cb_s1   <= pixel_in.payload.chroma_blue;
			cr_s1   <= pixel_in.payload.chroma_red;
			load_s1 <= touch;
			odd_s1  <= odd_eff;
		end
	end

	// Chroma selection and the four products.
	logic [2*SAMPLE_W-1:0]  held_q;
	logic [2*SAMPLE_W-1:0]  chroma_sel;
	logic signed [8:0]      u_val, v_val;
	logic signed [18:0]     prod_r, prod_gu, prod_gv, prod_b;
	coef_set_t              coef;

	always_comb begin
		if (!load_s1) begin
			chroma_sel = held_q;
		end else if (odd_s1) begin
			chroma_sel = rd_q;
		end else begin
			chroma_sel = {cr_s1, cb_s1};
		end
		u_val   = $signed({1'b0, chroma_sel[SAMPLE_W-1:0]}) - $signed({1'b0, CHROMA_OFFSET});
		v_val   = $signed({1'b0, chroma_sel[2*SAMPLE_W-1:SAMPLE_W]})
			- $signed({1'b0, CHROMA_OFFSET});
		coef    = coef_lookup(color_standard_q);
		prod_r  = coef.krv * v_val;
		prod_gu = coef.kgu * u_val;
		prod_gv = coef.kgv * v_val;
		prod_b  = coef.kbu * u_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (advance && valid_s1) begin
			held_q <= chroma_sel;
		end
	end

	// Stage 2 registers: products and luma.
	logic [SAMPLE_W-1:0] y_s2;
	logic signed [18:0]  prod_r_s2, prod_gu_s2, prod_gv_s2, prod_b_s2;

	always_ff @(posedge clk) begin
		if (advance) begin
			y_s2       <= y_s1;
			prod_r_s2  <= prod_r;
			prod_gu_s2 <= prod_gu;
			prod_gv_s2 <= prod_gv;
			prod_b_s2  <= prod_b;
		end
	end

	// Floor the signed Q10.8 products and Q11.8 green sum by an arithmetic shift, add luma and clamp each channel.
	logic signed [19:0] g_sum;
	logic signed [12:0] y_ext, r_val, g_val, b_val;

	always_comb begin
		g_sum = 20'(prod_gu_s2) + 20'(prod_gv_s2);
		y_ext = $signed({5'b0, y_s2});
		r_val = y_ext + 13'($signed(prod_r_s2[18:FRAC_BITS]));
		g_val = y_ext + 13'($signed(g_sum[19:FRAC_BITS]));
		b_val = y_ext + 13'($signed(prod_b_s2[18:FRAC_BITS]));
	end

	// Output register.
	pixel_out_t out_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.red   <= clamp_sample(r_val);
			out_q.green <= clamp_sample(g_val);
			out_q.blue  <= clamp_sample(b_val);
		end
	end

	// Valid flags for each stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= accept;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	assign pixel_out.valid   = out_valid_q;
	assign pixel_out.payload = out_q;

endmodule
